### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BCV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Boolean condition must never be seen outside reset.
`define BCV_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `BCV_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

### rtl/bcv_pkg.sv
// Package: widths, codes and types of the backlash compensating velocity block.
`timescale 1ns / 1ps
`default_nettype none
package bcv_pkg;

  localparam int POS_W    = 32;
  localparam int DIFF_W   = POS_W + 1;
  localparam int VEL_W    = 48;
  localparam int ALPHA_W  = 17;
  localparam int TICK_W   = 16;
  localparam int RATE_W   = 16;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = 4;
  localparam int FRAC_W   = 16;

  localparam int MUL_A_W  = VEL_W + 1;
  localparam int MUL_B_W  = ALPHA_W;
  localparam int MUL_P_W  = 66;

  localparam int DIV_W     = 50;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(65536);
  localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(32768);

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_UNKNOWN   = 3'd0,
    MODE_BACK_OK   = 3'd1,
    MODE_FWD_OK    = 3'd2,
    MODE_BACK_SLOP = 3'd3,
    MODE_FWD_SLOP  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_BLEND_ALPHA = 2'd0,
    REG_SLOP_TICKS  = 2'd1,
    REG_SAMPLE_RATE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [TICK_W-1:0]       divisor;
  } div_req_t;

endpackage
`default_nettype wire

### rtl/backlash_compensating_velocity_top.sv
// Top level: sequencer, state and register port of the velocity estimator.
//
// Usage:
//   One position sample (signed Q16.16) enters per transaction on the input
//   channel (in_valid_i / in_ready_o). Each sample yields exactly one result
//   transaction on the output channel: velocity (Q16.16 per second, 48-bit
//   saturating) and the backlash mode.
//   in_ready_o is high only while the sequencer is idle. The time from one
//   acceptance to the next, and to the valid result, is set by the single
//   shared multiplier (four products per sample, five when the difference is
//   scaled in slop) and the radix-4 slop divider.
//   The result sits in an output register, so a new sample may be accepted
//   while it waits. If the receiver stalls so long that a second result is
//   ready, the sequencer holds it and stays busy until the register frees.
//   Reset clears the state (first sample gives velocity 0, mode unknown) and
//   loads register defaults: blend_alpha 0, slop_ticks 10, sample_rate 1000.
//   Registers sit on the APB port at 0x0, 0x4, 0x8; write them only while idle.
`timescale 1ns / 1ps
`default_nettype none
module backlash_compensating_velocity_top import bcv_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [POS_W-1:0]  position_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [VEL_W-1:0]       velocity_o,
  output logic [2:0]                    mode_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [CFG_W-1:0]         pwdata,
  output logic [CFG_W-1:0]              prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RATE,
    S_SAT,
    S_BLEND,
    S_DONE,
    S_CHK,
    S_DIVGO,
    S_DIVW
  } state_e;

  state_e                    state_q, state_d;
  logic                      pass_q, pass_d;
  logic                      started_q, started_d;
  mode_e                     mode_q, mode_d;
  logic [TICK_W-1:0]         cnt_q, cnt_d;
  logic signed [POS_W-1:0]   prev_q, prev_d;
  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [DIFF_W-1:0]  scaled_q, scaled_d;
  logic signed [VEL_W-1:0]   raw_q, raw_d;
  logic signed [VEL_W-1:0]   dv_q, dv_d;
  logic signed [VEL_W-1:0]   fv_q, fv_d;
  logic signed [VEL_W-1:0]   vel_out_q, vel_out_d;
  mode_e                     mode_out_q, mode_out_d;
  logic                      out_valid_q, out_valid_d;
  logic [ALPHA_W-1:0]        alpha_q, alpha_d;
  logic [TICK_W-1:0]         ticks_q, ticks_d;
  logic [RATE_W-1:0]         rate_q, rate_d;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] mul_p;
  div_req_t                  div_req;
  logic                      div_done;
  logic signed [DIFF_W-1:0]  div_quo;

  logic [ALPHA_W-1:0]        alpha_eff;
  logic                      ovf;
  logic signed [VEL_W-1:0]   raw_sat;
  logic [MUL_P_W-1:0]        p_rnd;
  logic signed [VEL_W+1:0]   rnd_sh;
  logic signed [VEL_W+1:0]   sum_w;
  logic signed [VEL_W-1:0]   blend_res;
  logic signed [VEL_W-1:0]   prev_sel;
  logic signed [DIFF_W-1:0]  rate_src;
  logic [TICK_W-1:0]         cnt_inc;
  logic                      dir_neg, dir_pos;
  logic                      do_scale;
  logic                      cfg_wr;

  bcv_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  bcv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

  // 48-bit saturation of the registered product
  assign ovf     = !((&mul_p[MUL_P_W-1:VEL_W-1]) || (~|mul_p[MUL_P_W-1:VEL_W-1]));
  assign raw_sat = ovf ? (mul_p[MUL_P_W-1] ? VEL_MIN : VEL_MAX) : mul_p[VEL_W-1:0];

  // blend = raw + round(alpha * (prev - raw) / 2^16), rounding half up
  assign p_rnd     = mul_p + ROUND_HALF;
  assign rnd_sh    = p_rnd[MUL_P_W-1:FRAC_W];
  assign sum_w     = {{2{raw_q[VEL_W-1]}}, raw_q} + rnd_sh;
  assign blend_res = sum_w[VEL_W-1:0];

  assign prev_sel = pass_q ? fv_q : dv_q;
  assign rate_src = pass_q ? scaled_q : diff_q;

  assign cnt_inc = (cnt_q == {TICK_W{1'b1}}) ? cnt_q : cnt_q + TICK_W'(1);
  assign dir_neg = blend_res[VEL_W-1];
  assign dir_pos = !blend_res[VEL_W-1] && (|blend_res);

  assign do_scale = ((mode_q == MODE_BACK_SLOP) || (mode_q == MODE_FWD_SLOP)) &&
                    (ticks_q != '0) && (cnt_q < ticks_q);

  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    started_d   = started_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    diff_d      = diff_q;
    scaled_d    = scaled_q;
    raw_d       = raw_q;
    dv_d        = dv_q;
    fv_d        = fv_q;
    vel_out_d   = vel_out_q;
    mode_out_d  = mode_out_q;
    out_valid_d = out_valid_q;
    alpha_d     = alpha_q;
    ticks_d     = ticks_q;
    rate_d      = rate_q;
    mul_req     = '0;
    div_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_BLEND_ALPHA: alpha_d = pwdata[ALPHA_W-1:0];
        REG_SLOP_TICKS:  ticks_d = pwdata[TICK_W-1:0];
        REG_SAMPLE_RATE: rate_d  = pwdata[RATE_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d     = position_i;
          // first sample: difference is zero
          diff_d    = started_q ? ({position_i[POS_W-1], position_i} - {prev_q[POS_W-1], prev_q})
                                : '0;
          started_d = 1'b1;
          pass_d    = 1'b0;
          state_d   = S_RATE;
        end
      end
      S_RATE: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(MUL_A_W-DIFF_W){rate_src[DIFF_W-1]}}, rate_src};
        mul_req.b  = {1'b0, rate_q};
        state_d    = S_SAT;
      end
      S_SAT: begin
        raw_d   = raw_sat;
        state_d = S_BLEND;
      end
      S_BLEND: begin
        mul_req.en = 1'b1;
        mul_req.a  = {prev_sel[VEL_W-1], prev_sel} - {raw_q[VEL_W-1], raw_q};
        mul_req.b  = alpha_eff;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!pass_q) begin
          dv_d  = blend_res;
          cnt_d = cnt_inc;
          case (mode_q)
            MODE_UNKNOWN: begin
              if (dir_neg) mode_d = MODE_BACK_OK;
              else if (dir_pos) mode_d = MODE_FWD_OK;
            end
            MODE_BACK_OK: begin
              if (dir_pos) begin
                cnt_d  = '0;
                mode_d = MODE_FWD_SLOP;
              end
            end
            MODE_FWD_OK: begin
              if (dir_neg) begin
                cnt_d  = '0;
                mode_d = MODE_BACK_SLOP;
              end
            end
            MODE_BACK_SLOP: begin
              if (dir_pos) begin
                cnt_d  = '0;
                mode_d = MODE_FWD_SLOP;
              end else if (cnt_inc > ticks_q) begin
                cnt_d  = '0;
                mode_d = MODE_BACK_OK;
              end
            end
            MODE_FWD_SLOP: begin
              if (dir_neg) begin
                cnt_d  = '0;
                mode_d = MODE_BACK_SLOP;
              end else if (cnt_inc > ticks_q) begin
                cnt_d  = '0;
                mode_d = MODE_FWD_OK;
              end
            end
            default: mode_d = MODE_UNKNOWN;
          endcase
          state_d = S_CHK;
        end else if (!out_valid_q || out_ready_i) begin
          fv_d        = blend_res;
          prev_d      = pos_q;
          vel_out_d   = blend_res;
          mode_out_d  = mode_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_CHK: begin
        if (do_scale) begin
          mul_req.en = 1'b1;
          mul_req.a  = {{(MUL_A_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
          mul_req.b  = {1'b0, cnt_q};
          state_d    = S_DIVGO;
        end else begin
          scaled_d = diff_q;
          pass_d   = 1'b1;
          state_d  = S_RATE;
        end
      end
      S_DIVGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p[DIV_W-1:0];
        div_req.divisor  = ticks_q;
        state_d          = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          scaled_d = div_quo;
          pass_d   = 1'b1;
          state_d  = S_RATE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      started_q   <= 1'b0;
      mode_q      <= MODE_UNKNOWN;
      cnt_q       <= '0;
      prev_q      <= '0;
      pos_q       <= '0;
      diff_q      <= '0;
      scaled_q    <= '0;
      raw_q       <= '0;
      dv_q        <= '0;
      fv_q        <= '0;
      vel_out_q   <= '0;
      mode_out_q  <= MODE_UNKNOWN;
      out_valid_q <= 1'b0;
      alpha_q     <= '0;
      ticks_q     <= TICK_W'(10);
      rate_q      <= RATE_W'(1000);
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      started_q   <= started_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      pos_q       <= pos_d;
      diff_q      <= diff_d;
      scaled_q    <= scaled_d;
      raw_q       <= raw_d;
      dv_q        <= dv_d;
      fv_q        <= fv_d;
      vel_out_q   <= vel_out_d;
      mode_out_q  <= mode_out_d;
      out_valid_q <= out_valid_d;
      alpha_q     <= alpha_d;
      ticks_q     <= ticks_d;
      rate_q      <= rate_d;
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_BLEND_ALPHA: prdata = {{(CFG_W-ALPHA_W){1'b0}}, alpha_q};
      REG_SLOP_TICKS:  prdata = {{(CFG_W-TICK_W){1'b0}}, ticks_q};
      REG_SAMPLE_RATE: prdata = {{(CFG_W-RATE_W){1'b0}}, rate_q};
      default:         prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign velocity_o  = vel_out_q;
  assign mode_o      = mode_out_q;

endmodule
`default_nettype wire

### rtl/bcv_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module bcv_mul import bcv_pkg::*; (
  input  wire logic                      clk_i,
  input  wire mul_req_t                  req_i,
  output logic signed [MUL_P_W-1:0]      prod_o
);

  logic signed [MUL_A_W+MUL_B_W:0] full;
  logic signed [MUL_P_W-1:0]       prod_q;

  assign full = $signed(req_i.a) * $signed({1'b0, req_i.b});

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= full[MUL_P_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

### rtl/bcv_div.sv
// Signed-by-unsigned restoring divider, two quotient bits per cycle, truncating.
`timescale 1ns / 1ps
`default_nettype none
module bcv_div import bcv_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire div_req_t                req_i,
  output logic                         done_o,
  output logic signed [DIFF_W-1:0]     quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic                 neg_q;
  logic [TICK_W-1:0]    rem_q;
  logic [DIV_W-1:0]     shf_q;
  logic [TICK_W-1:0]    dsr_q;

  logic [DIV_W-1:0]     mag;
  logic [TICK_W:0]      r1, r2, rm1, rm2;
  logic                 ge1, ge2;
  logic [DIV_W-1:0]     sh1, sh2;
  logic [DIFF_W-1:0]    q_mag;

  assign mag = req_i.dividend[DIV_W-1] ? (~req_i.dividend + DIV_W'(1)) : req_i.dividend;

  always_comb begin
    r1  = {rem_q, shf_q[DIV_W-1]};
    ge1 = (r1 >= {1'b0, dsr_q});
    rm1 = ge1 ? (r1 - {1'b0, dsr_q}) : r1;
    sh1 = {shf_q[DIV_W-2:0], ge1};
    r2  = {rm1[TICK_W-1:0], sh1[DIV_W-1]};
    ge2 = (r2 >= {1'b0, dsr_q});
    rm2 = ge2 ? (r2 - {1'b0, dsr_q}) : r2;
    sh2 = {sh1[DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        step_q <= step_q - DIV_CNT_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DIV_W-1];
      rem_q <= '0;
      shf_q <= mag;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rm2[TICK_W-1:0];
      shf_q <= sh2;
    end
  end

  assign q_mag      = shf_q[DIFF_W-1:0];
  assign quotient_o = neg_q ? -$signed(q_mag) : $signed(q_mag);
  assign done_o     = done_q;

endmodule
`default_nettype wire

### rtl/bcv_checker.sv
// Port-level checker for the velocity estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bcv_checker import bcv_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [VEL_W-1:0]  velocity_o,
  input wire logic [2:0]               mode_o
);

  // stalled result holds
  `BCV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(velocity_o) && $stable(mode_o), "stalled result changed")

  // one sample in flight at a time
  `BCV_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "accepted a transaction while busy")

  // no result can appear right after a sample is taken
  `BCV_ASSERT(a_no_early_result, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result appeared one cycle after accept")

  // a new result is only posted as the sequencer returns to idle
  `BCV_ASSERT_NEVER(a_result_frees_input, clk_i, rst_ni, $rose(out_valid_o) && !in_ready_o, "result posted while still busy")

endmodule

bind backlash_compensating_velocity_top bcv_checker u_bcv_checker (.*);
`default_nettype wire
